/* rtl/assert_macros.svh */
// Assertion helpers for the fitness statistics / roulette select block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FSRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FSRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define FSRS_ASSERT(lbl, clk, rstn, prop, msg)
`define FSRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/fsrs_pkg.sv */
`timescale 1ns / 1ps

package fsrs_pkg;

  localparam int POP_MAX_DEF      = 256;
  localparam int FITNESS_BITS_DEF = 32;
  localparam int TOTAL_BITS       = 40;
  localparam int WORST_START      = 9999999;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 8;
  localparam int FIT_IN_W = 32;
  localparam int FRAC_W   = 16;
  localparam int SIZE_W   = 9;
  localparam int OUT_W    = 32;

  localparam int IN_DATA_W  = INDEX_W + FIT_IN_W + FRAC_W;
  localparam int OUT_DATA_W = 2 * INDEX_W + 3 * OUT_W + TOTAL_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_STATS  = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

endpackage

/* rtl/fsrs_ram.sv */
`timescale 1ns / 1ps

module fsrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fsrs_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module fsrs_div #(
  parameter int DW = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [fsrs_pkg::TOTAL_BITS-1:0] dividend_i,
  input  logic [DW-1:0]                   divisor_i,
  output logic                            done_o,
  output logic [fsrs_pkg::TOTAL_BITS-1:0] quotient_o
);

  localparam int TB = fsrs_pkg::TOTAL_BITS;
  localparam int CW = $clog2(TB + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [TB-1:0] quo_q, quo_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[TB-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      quo_d = {quo_q[TB-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(TB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/fitness_stats_roulette_select.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fitness table with statistics and roulette-wheel selection.
// Input stream: s_axis_tuser carries the mode (write, statistics, select, no-op);
// s_axis_tdata carries index, fitness and random fraction. Every request
// gives exactly one result on the output stream: m_axis_tuser is the found
// flag, m_axis_tdata the selected index and the stored statistics.
// cfg_we_i/cfg_wdata_i set the population size (reset 256); write it only
// while no request is in flight.
// One request at a time; s_axis_tready is high only while the sequencer idles,
// so a request holds the block until its result enters the output register.
// Per request: a write or no-op goes straight to the finish state;
// statistics reads the first N table entries, one per cycle, then runs
// the bit-serial divider for the average; select does one multiply, then
// one table read per cycle until the running sum reaches the slice.
// N is the population size in use.
// The result sits in an output register; a stalled receiver holds it, and
// the block may take and finish the next request meanwhile, waiting only
// when it must hand over a second result.
// Reset clears the statistics (worst to 9999999) but not the table.
module fitness_stats_roulette_select #(
  parameter int POP_MAX      = fsrs_pkg::POP_MAX_DEF,
  parameter int FITNESS_BITS = fsrs_pkg::FITNESS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fsrs_pkg::SIZE_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // index[7:0], fitness[39:8], random_fraction[55:40]
  input  logic [fsrs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode[1:0]
  input  logic [fsrs_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // selected_index[7:0], best_index[15:8], best_fitness[47:16],
  // worst_fitness[79:48], total_fitness[119:80], average_fitness[151:120]
  output logic [fsrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // found[0]
  output logic [0:0]                        m_axis_tuser
);

  localparam int TB = fsrs_pkg::TOTAL_BITS;
  localparam int AW = $clog2(POP_MAX);
  localparam int NW = $clog2(POP_MAX + 1);
  localparam int FW = (FITNESS_BITS > 32) ? FITNESS_BITS : 32;
  localparam int SW = ((FITNESS_BITS > TB) ? FITNESS_BITS : TB) + 1;
  localparam int OW = fsrs_pkg::OUT_W;
  localparam int IW = fsrs_pkg::INDEX_W;
  localparam int FRW = fsrs_pkg::FRAC_W;
  localparam logic [FW-1:0] WORST_INIT = FW'(fsrs_pkg::WORST_START);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_WALK = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [fsrs_pkg::SIZE_W-1:0] size_q;
  logic [31:0]   size_w;
  logic [31:0]   n_w;
  logic [NW-1:0] n;

  logic [IW-1:0]                  in_index;
  logic [fsrs_pkg::FIT_IN_W-1:0] in_fit;
  logic [FRW-1:0]                 in_frac;
  fsrs_pkg::mode_e                in_mode;
  logic [31:0]                    idx_w;
  logic [FW-1:0]                  fit_ext;

  logic                    ram_we;
  logic                    issue;
  logic [FITNESS_BITS-1:0] rd_data;
  logic [FW-1:0]           v_ext;

  logic [NW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          stats_q, stats_d;

  logic [TB-1:0] tot_q, tot_d;
  logic [FW-1:0] best_q, best_d;
  logic [AW-1:0] bidx_q, bidx_d;
  logic [FW-1:0] worst_q, worst_d;
  logic [OW-1:0] avg_q, avg_d;

  logic [FRW-1:0]    frac_q, frac_d;
  logic [TB-1:0]     slice_q, slice_d;
  logic [TB+FRW-1:0] prod;
  logic [SW-1:0]     sum_q, sum_d;
  logic [SW-1:0]     sum_add;
  logic [SW-1:0]     tot_add;
  logic              found_q, found_d;
  logic [AW-1:0]     sel_q, sel_d;

  logic                            div_start;
  logic                            div_done;
  logic [TB-1:0]                   div_quo;

  logic                            out_vld_q, out_vld_d;
  logic [fsrs_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                            out_user_q, out_user_d;

  assign size_w = 32'(size_q);
  assign n_w    = (size_w >= 32'(POP_MAX)) ? 32'(POP_MAX) : size_w;
  assign n      = n_w[NW-1:0];

  assign in_index = s_axis_tdata[IW-1:0];
  assign in_fit   = s_axis_tdata[IW+fsrs_pkg::FIT_IN_W-1:IW];
  assign in_frac  = s_axis_tdata[fsrs_pkg::IN_DATA_W-1:IW+fsrs_pkg::FIT_IN_W];
  assign in_mode  = fsrs_pkg::mode_e'(s_axis_tuser);
  assign idx_w    = 32'(in_index);
  assign fit_ext  = FW'(in_fit);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign ram_we = s_axis_tvalid && s_axis_tready && (in_mode == fsrs_pkg::MODE_WRITE)
                  && (idx_w < n_w);
  assign issue  = (state_q == ST_WALK) && (cnt_q < n);

  fsrs_ram #(
    .WIDTH (FITNESS_BITS),
    .DEPTH (POP_MAX)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_w[AW-1:0]),
    .wdata_i (fit_ext[FITNESS_BITS-1:0]),
    .re_i    (issue),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  fsrs_div #(
    .DW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tot_q),
    .divisor_i  (n),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign v_ext   = FW'(rd_data);
  assign prod    = frac_q * tot_q;
  assign sum_add = sum_q + SW'(rd_data);
  assign tot_add = SW'(tot_q) + SW'(rd_data);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    stats_d    = stats_q;
    tot_d      = tot_q;
    best_d     = best_q;
    bidx_d     = bidx_q;
    worst_d    = worst_q;
    avg_d      = avg_q;
    frac_d     = frac_q;
    slice_d    = slice_q;
    sum_d      = sum_q;
    found_d    = found_q;
    sel_d      = sel_q;
    div_start  = 1'b0;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;

    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d   = '0;
          found_d = 1'b0;
          sel_d   = '0;
          case (in_mode)
            fsrs_pkg::MODE_STATS: begin
              stats_d = 1'b1;
              tot_d   = '0;
              best_d  = '0;
              bidx_d  = '0;
              worst_d = WORST_INIT;
              state_d = ST_WALK;
            end
            fsrs_pkg::MODE_SELECT: begin
              stats_d = 1'b0;
              frac_d  = in_frac;
              sum_d   = '0;
              state_d = ST_MUL;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_MUL: begin
        slice_d = prod[TB+FRW-1:FRW];
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (stats_q) begin
            if (v_ext > best_q) begin
              best_d = v_ext;
              bidx_d = rd_idx_q;
            end
            if (v_ext < worst_q) begin
              worst_d = v_ext;
            end
            tot_d = (tot_add[SW-1:TB] != '0) ? '1 : tot_add[TB-1:0];
          end else begin
            sum_d = sum_add;
            if (sum_add >= SW'(slice_q)) begin
              found_d = 1'b1;
              sel_d   = rd_idx_q;
              state_d = ST_FIN;
            end
          end
        end else if (!issue) begin
          if (stats_q) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = (n == '0) ? '0 : div_quo[OW-1:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_user_d = found_q;
          out_data_d = {avg_q, tot_q, worst_q[OW-1:0], best_q[OW-1:0],
                        IW'(bidx_q), IW'(sel_q)};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      size_q    <= fsrs_pkg::SIZE_W'(fsrs_pkg::POP_MAX_DEF);
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      stats_q   <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      tot_q     <= '0;
      best_q    <= '0;
      bidx_q    <= '0;
      worst_q   <= WORST_INIT;
      avg_q     <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      cnt_q     <= cnt_d;
      rd_vld_q  <= issue;
      stats_q   <= stats_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      tot_q     <= tot_d;
      best_q    <= best_d;
      bidx_q    <= bidx_d;
      worst_q   <= worst_d;
      avg_q     <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= cnt_q[AW-1:0];
    frac_q     <= frac_d;
    slice_q    <= slice_d;
    sum_q      <= sum_d;
    sel_q      <= sel_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `FSRS_ASSERT_IMP(a_rd_in_walk, clk_i, rst_ni, rd_vld_q, $past(state_q == ST_WALK), "stray read")
  `FSRS_ASSERT_IMP(a_div_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV, "stray divide")
  `FSRS_ASSERT_IMP(a_found_sel, clk_i, rst_ni, found_q, !stats_q, "found in statistics")
  `FSRS_ASSERT_IMP(a_out_fin, clk_i, rst_ni, $rose(m_axis_tvalid), $past(state_q == ST_FIN), "no finish")

endmodule
